### hw/rtl/line_segment_window_clipper_assert.svh
// Assertion macros for the segment clipper. Each macro expects clk and rst_n in scope.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_ASSERT_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment clipper assertion failed");
`define LSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment clipper assertion failed");
`else
`define LSC_ASSERT_IMP(lbl, ante, cons)
`define LSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/lsc_pkg.sv
package lsc_pkg;

  // Outcode bits.
  localparam logic [3:0] CODE_UP    = 4'b0001;
  localparam logic [3:0] CODE_DOWN  = 4'b0010;
  localparam logic [3:0] CODE_RIGHT = 4'b0100;
  localparam logic [3:0] CODE_LEFT  = 4'b1000;

  // Configuration register indexes.
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_X_MAX = 2'd1;
  localparam logic [1:0] REG_Y_MIN = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  localparam int ProdW  = 50;
  localparam int DivW   = 25;

  typedef struct packed {
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
  } in_t;

  typedef struct packed {
    logic               clip_status;
    logic signed [23:0] out_first_x;
    logic signed [23:0] out_first_y;
    logic signed [23:0] out_second_x;
    logic signed [23:0] out_second_y;
  } out_t;

  // Outcode of a point against window edges already scaled to Q.8.
  function automatic logic [3:0] outcode(
    input logic signed [23:0] x, input logic signed [23:0] y,
    input logic signed [23:0] xmin, input logic signed [23:0] xmax,
    input logic signed [23:0] ymin, input logic signed [23:0] ymax);
    logic [3:0] c;
    c = 4'b0000;
    if (y < ymin) c = c | CODE_UP;
    if (y > ymax) c = c | CODE_DOWN;
    if (x > xmax) c = c | CODE_RIGHT;
    if (x < xmin) c = c | CODE_LEFT;
    return c;
  endfunction

endpackage

### hw/rtl/lsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lsc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsc_pkg::ProdW-1:0]     dividend,
  input  logic [lsc_pkg::DivW-1:0]      divisor,
  output logic                          done,
  output logic [lsc_pkg::ProdW-1:0]     quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [5:0]                  cnt_r, cnt_nxt;
  logic [lsc_pkg::DivW:0]      rem_r, rem_nxt;
  logic [lsc_pkg::ProdW-1:0]   num_r, num_nxt;
  logic [lsc_pkg::DivW-1:0]    div_r, div_nxt;
  logic [lsc_pkg::DivW:0]      trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    div_nxt  = div_r;
    trial    = {rem_r[lsc_pkg::DivW-1:0], num_r[lsc_pkg::ProdW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      num_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        num_nxt = {num_r[lsc_pkg::ProdW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[lsc_pkg::ProdW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(lsc_pkg::ProdW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

### hw/rtl/line_segment_window_clipper.sv
// Cohen-Sutherland segment clipper.
// Input channel in_valid/in_stall/in_data carries one segment word: two endpoints
// in signed Q16.8. Output channel out_valid/out_stall/out_data returns one word per
// segment: a status bit (1 = rejected, endpoints zero) and the clipped endpoints.
// The window edges are written through cfg_valid/cfg_ready/cfg_index/cfg_data as
// whole units; cfg_ready is always high. The user must make writes only while the
// block is idle; the block itself does not enforce this. Each segment runs through
// up to 16 passes of outcode test and edge move. A pass that resolves the segment
// runs the outcode test and the result write. A pass that moves an endpoint runs the
// outcode test, multiply, sign setup, the divider (50 restoring steps and the done
// strobe, skipped when the denominator is zero) and the add. in_stall is high while a
// segment is in work; a finished word sits in the output register while the next
// segment is taken, and the sequencer holds its result if out_stall keeps that
// register full.
// Synchronous active-low reset clears the window to zero and empties the block.
module line_segment_window_clipper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lsc_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsc_pkg::out_t        out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic signed [15:0]   cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CODE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SGN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [4:0]                pass_r, pass_nxt;
  logic signed [15:0]        xmin_r, xmax_r, ymin_r, ymax_r;
  logic signed [23:0]        x1_r, y1_r, x2_r, y2_r;
  logic signed [23:0]        x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic signed [23:0]        a_r, a_nxt, e_r, e_nxt;
  logic signed [24:0]        dba_r, dba_nxt, dep_r, dep_nxt, den_r, den_nxt;
  logic                      vert_r, vert_nxt;
  logic signed [49:0]        prod_r, prod_nxt;
  logic                      neg_r, neg_nxt, zden_r, zden_nxt;
  logic                      acc_r, acc_nxt;
  lsc_pkg::out_t             out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [23:0]        exmin, exmax, eymin, eymax;
  logic [3:0]                c1, c2, cm;
  logic signed [23:0]        px1, py1, px2, py2;
  logic                      div_start;
  logic                      div_done;
  logic [49:0]               quo;
  logic [49:0]               pmag;
  logic [24:0]               dmag;
  logic signed [26:0]        qs;
  logic signed [23:0]        moved;

  // Window edges in Q.8.
  assign exmin = {xmin_r, 8'h00};
  assign exmax = {xmax_r, 8'h00};
  assign eymin = {ymin_r, 8'h00};
  assign eymax = {ymax_r, 8'h00};

  assign c1 = lsc_pkg::outcode(x1_r, y1_r, exmin, exmax, eymin, eymax);
  assign c2 = lsc_pkg::outcode(x2_r, y2_r, exmin, exmax, eymin, eymax);

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= '0;
      xmax_r <= '0;
      ymin_r <= '0;
      ymax_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsc_pkg::REG_X_MIN: xmin_r <= cfg_data;
        lsc_pkg::REG_X_MAX: xmax_r <= cfg_data;
        lsc_pkg::REG_Y_MIN: ymin_r <= cfg_data;
        lsc_pkg::REG_Y_MAX: ymax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand magnitudes for the divider.
  assign pmag = prod_r[49] ? 50'(-prod_r) : 50'(prod_r);
  assign dmag = den_r[24] ? 25'(-den_r) : 25'(den_r);
  assign div_start = (state_r == S_SGN) && (den_r != '0);

  lsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pmag),
    .divisor  (dmag),
    .done     (div_done),
    .quotient (quo)
  );

  // Signed, truncated quotient and the moved coordinate.
  assign qs    = zden_r ? 27'sd0 : (neg_r ? -$signed({1'b0, quo[25:0]})
                                          : $signed({1'b0, quo[25:0]}));
  assign moved = 24'(27'(a_r) + qs);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    a_nxt         = a_r;
    e_nxt         = e_r;
    dba_nxt       = dba_r;
    dep_nxt       = dep_r;
    den_nxt       = den_r;
    vert_nxt      = vert_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    zden_nxt      = zden_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    px1           = x1_r;
    py1           = y1_r;
    px2           = x2_r;
    py2           = y2_r;
    cm            = c1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x1_nxt    = in_data.start_x;
          y1_nxt    = in_data.start_y;
          x2_nxt    = in_data.end_x;
          y2_nxt    = in_data.end_y;
          pass_nxt  = '0;
          state_nxt = S_CODE;
        end
      end
      S_CODE: begin
        if (pass_r == 5'd16 || (c1 & c2) != 4'b0000) begin
          acc_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if ((c1 | c2) == 4'b0000) begin
          acc_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          // Put the outside endpoint first.
          if (c1 == 4'b0000) begin
            px1 = x2_r;
            py1 = y2_r;
            px2 = x1_r;
            py2 = y1_r;
            cm  = c2;
          end
          x1_nxt = px1;
          y1_nxt = py1;
          x2_nxt = px2;
          y2_nxt = py2;
          // First violated edge, in the order up, down, right, left.
          if ((cm & (lsc_pkg::CODE_UP | lsc_pkg::CODE_DOWN)) != 4'b0000) begin
            vert_nxt = 1'b1;
            e_nxt    = ((cm & lsc_pkg::CODE_UP) != 4'b0000) ? eymin : eymax;
            a_nxt    = px1;
            dba_nxt  = 25'(px2) - 25'(px1);
            dep_nxt  = 25'(e_nxt) - 25'(py1);
            den_nxt  = 25'(py2) - 25'(py1);
          end else begin
            vert_nxt = 1'b0;
            e_nxt    = ((cm & lsc_pkg::CODE_RIGHT) != 4'b0000) ? exmax : exmin;
            a_nxt    = py1;
            dba_nxt  = 25'(py2) - 25'(py1);
            dep_nxt  = 25'(e_nxt) - 25'(px1);
            den_nxt  = 25'(px2) - 25'(px1);
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = dba_r * dep_r;
        state_nxt = S_SGN;
      end
      S_SGN: begin
        neg_nxt  = prod_r[49] ^ den_r[24];
        zden_nxt = (den_r == '0);
        state_nxt = (den_r == '0) ? S_ADD : S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ADD;
      end
      S_ADD: begin
        if (vert_r) begin
          x1_nxt = moved;
          y1_nxt = e_r;
        end else begin
          y1_nxt = moved;
          x1_nxt = e_r;
        end
        pass_nxt  = pass_r + 5'd1;
        state_nxt = S_CODE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.clip_status  = !acc_r;
          out_nxt.out_first_x  = acc_r ? x1_r : '0;
          out_nxt.out_first_y  = acc_r ? y1_r : '0;
          out_nxt.out_second_x = acc_r ? x2_r : '0;
          out_nxt.out_second_y = acc_r ? y2_r : '0;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x1_r   <= x1_nxt;
    y1_r   <= y1_nxt;
    x2_r   <= x2_nxt;
    y2_r   <= y2_nxt;
    a_r    <= a_nxt;
    e_r    <= e_nxt;
    dba_r  <= dba_nxt;
    dep_r  <= dep_nxt;
    den_r  <= den_nxt;
    vert_r <= vert_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    zden_r <= zden_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencer and result register.
  `include "line_segment_window_clipper_assert.svh"
  `LSC_ASSERT_NXT(a_take_code, in_valid && !in_stall, state_r == S_CODE)
  `LSC_ASSERT_IMP(a_div_nonzero, state_r == S_DIV, den_r != '0)
  `LSC_ASSERT_IMP(a_pass_bound, state_r != S_IDLE, pass_r <= 5'd16)
  `LSC_ASSERT_IMP(a_reject_zero, out_valid_r && out_r.clip_status,
    out_r.out_first_x == '0 && out_r.out_second_y == '0)

endmodule

### tb/tb_line_segment_window_clipper.sv
`timescale 1ns / 100ps

module tb_line_segment_window_clipper;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 260;
  localparam int RandomPhases = 8;
  localparam int WordsPerPhase = 100;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  lsc_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  lsc_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic signed [15:0] cfg_data;

  line_segment_window_clipper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Window mirror, in whole units.
  logic signed [15:0] win_x_min, win_x_max, win_y_min, win_y_max;

  lsc_pkg::out_t clipped_q[$];
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int rejected_seen = 0;
  int idle_cycles = 0;
  int stall_pct = 0;
  int stall_hold = 0;
  bit gaps_on = 1;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Region code of a Q.8 point against the current window.
  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = 4'b0000;
    if (y < longint'(win_y_min) * 256) c = c | lsc_pkg::CODE_UP;
    if (y > longint'(win_y_max) * 256) c = c | lsc_pkg::CODE_DOWN;
    if (x > longint'(win_x_max) * 256) c = c | lsc_pkg::CODE_RIGHT;
    if (x < longint'(win_x_min) * 256) c = c | lsc_pkg::CODE_LEFT;
    return c;
  endfunction

  // Intersection along one axis, division truncating toward zero.
  function automatic longint edge_cross(longint a, longint b, longint e, longint p,
                                        longint q);
    if (q == p) return a;
    return a + ((b - a) * (e - p)) / (q - p);
  endfunction

  // Expected clipped segment for one input word.
  function automatic lsc_pkg::out_t clip_segment(lsc_pkg::in_t s);
    longint x1, y1, x2, y2, t, e;
    logic [3:0] c1, c2;
    bit accepted;
    lsc_pkg::out_t r;
    x1 = longint'($signed(s.start_x));
    y1 = longint'($signed(s.start_y));
    x2 = longint'($signed(s.end_x));
    y2 = longint'($signed(s.end_y));
    accepted = 0;
    for (int pass = 0; pass < 16; pass++) begin
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      if ((c1 & c2) != 0) break;
      if ((c1 | c2) == 0) begin
        accepted = 1;
        break;
      end
      if (c1 == 0) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        c1 = c2;
      end
      if ((c1 & lsc_pkg::CODE_UP) != 0) begin
        e = longint'(win_y_min) * 256;
        x1 = edge_cross(x1, x2, e, y1, y2);
        y1 = e;
      end else if ((c1 & lsc_pkg::CODE_DOWN) != 0) begin
        e = longint'(win_y_max) * 256;
        x1 = edge_cross(x1, x2, e, y1, y2);
        y1 = e;
      end else if ((c1 & lsc_pkg::CODE_RIGHT) != 0) begin
        e = longint'(win_x_max) * 256;
        y1 = edge_cross(y1, y2, e, x1, x2);
        x1 = e;
      end else begin
        e = longint'(win_x_min) * 256;
        y1 = edge_cross(y1, y2, e, x1, x2);
        x1 = e;
      end
    end
    r = '0;
    if (accepted) begin
      r.out_first_x = x1[23:0];
      r.out_first_y = y1[23:0];
      r.out_second_x = x2[23:0];
      r.out_second_y = y2[23:0];
    end else begin
      r.clip_status = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("MISMATCH %s", msg);
  endtask

  // Result checker.
  always @(posedge clk) begin
    lsc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (clipped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word at %0t", $realtime));
      end else begin
        want = clipped_q.pop_front();
        if (out_data.clip_status !== want.clip_status)
          report_mismatch($sformatf("word %0d clip_status: got %0d expected %0d",
                          words_checked, out_data.clip_status, want.clip_status));
        if (out_data.out_first_x !== want.out_first_x)
          report_mismatch($sformatf("word %0d out_first_x: got %0d expected %0d",
                          words_checked, out_data.out_first_x, want.out_first_x));
        if (out_data.out_first_y !== want.out_first_y)
          report_mismatch($sformatf("word %0d out_first_y: got %0d expected %0d",
                          words_checked, out_data.out_first_y, want.out_first_y));
        if (out_data.out_second_x !== want.out_second_x)
          report_mismatch($sformatf("word %0d out_second_x: got %0d expected %0d",
                          words_checked, out_data.out_second_x, want.out_second_x));
        if (out_data.out_second_y !== want.out_second_y)
          report_mismatch($sformatf("word %0d out_second_y: got %0d expected %0d",
                          words_checked, out_data.out_second_y, want.out_second_y));
        if (want.clip_status) rejected_seen++;
        words_checked++;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout with %0d results outstanding", clipped_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver stall, short bursts mostly and a long one now and then.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_hold <= ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Sends one word; called at a falling edge, returns at a falling edge.
  task automatic send_word(lsc_pkg::in_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    clipped_q = {clipped_q, clip_segment(w)};
    words_sent++;
    @(negedge clk);
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic drain();
    in_valid = 1'b0;
    while (clipped_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic signed [15:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      lsc_pkg::REG_X_MIN: win_x_min = v;
      lsc_pkg::REG_X_MAX: win_x_max = v;
      lsc_pkg::REG_Y_MIN: win_y_min = v;
      default: win_y_max = v;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_window(int xl, int xh, int yl, int yh);
    drain();
    write_reg(lsc_pkg::REG_X_MIN, 16'(xl));
    write_reg(lsc_pkg::REG_X_MAX, 16'(xh));
    write_reg(lsc_pkg::REG_Y_MIN, 16'(yl));
    write_reg(lsc_pkg::REG_Y_MAX, 16'(yh));
  endtask

  // Q.8 coordinate, mostly near the given unit span, sometimes anywhere.
  function automatic logic [23:0] near_coord(int lo, int hi);
    int a, b;
    if ($urandom_range(9) == 0) return 24'($urandom);
    a = ((lo < hi) ? lo : hi) - 48;
    b = ((lo < hi) ? hi : lo) + 48;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    return 24'((a + int'($urandom_range(b - a))) * 256 + int'($urandom_range(255)));
  endfunction

  typedef struct {
    bit new_win;
    int xl, xh, yl, yh;
    lsc_pkg::in_t seg;
    bit typed;
    lsc_pkg::out_t want;
  } stim_row_t;

  function automatic lsc_pkg::in_t seg(int x1, int y1, int x2, int y2);
    lsc_pkg::in_t s;
    s.start_x = 24'(x1);
    s.start_y = 24'(y1);
    s.end_x = 24'(x2);
    s.end_y = 24'(y2);
    return s;
  endfunction

  stim_row_t plan[$];

  // Appends one row to the directed table.
  task automatic add_row(stim_row_t r);
    plan = {plan, r};
  endtask

  initial begin
    lsc_pkg::in_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lsc_pkg::REG_X_MIN;
    cfg_data = '0;
    win_x_min = 0;
    win_x_max = 0;
    win_y_min = 0;
    win_y_max = 0;

    // Directed rows; typed results only where obvious.
    // Reset window is the single point at the origin.
    add_row('{0, 0, 0, 0, 0, seg(0, 0, 0, 0), 1, '{1'b0, 24'd0, 24'd0, 24'd0, 24'd0}});
    add_row('{0, 0, 0, 0, 0, seg(256, 0, 512, 0), 1, '{1'b1, 24'd0, 24'd0, 24'd0, 24'd0}});
    add_row('{0, 0, 0, 0, 0, seg(-8388608, -8388608, 8388607, 8388607), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(8388607, -8388608, -8388608, 8388607), 0, '0});
    // Ordinary window: inside, exchange, crossing every edge, a trivial reject.
    add_row('{1, -100, 100, -50, 50, seg(2560, 1280, -2560, -1280), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(0, 0, 51200, 3000), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(-40000, -20000, 40000, 20000), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(30000, -30000, -30000, 30000), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(-1000, -15000, 1000, -14000), 1,
             '{1'b1, 24'd0, 24'd0, 24'd0, 24'd0}});
    add_row('{0, 0, 0, 0, 0, seg(-30000, 100, 30000, -77), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(513, -20000, 513, 20000), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(-25601, 12801, 25601, -12801), 0, '0});
    // Inverted window: outcodes as written, loop may hit its pass limit.
    add_row('{1, 10, -10, 5, -5, seg(0, 0, 100, 50), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(-5000, 3000, 5000, -3000), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(2560, 1280, 2560, 1280), 0, '0});
    // Widest window against the field extremes.
    add_row('{1, -32768, 32767, -32768, 32767,
             seg(-8388608, -8388608, 8388607, 8388607), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(8388607, 0, 8388607, 100), 1,
             '{1'b1, 24'd0, 24'd0, 24'd0, 24'd0}});
    add_row('{0, 0, 0, 0, 0, seg(8388607, 8388607, -8388608, -1), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(-1, -1, 0, 0), 1,
             '{1'b0, -24'sd1, -24'sd1, 24'd0, 24'd0}});
    // Narrowest window at the opposite extreme.
    add_row('{1, 32767, 32767, -32768, -32768, seg(-8388608, -8388608, 8388607, 0), 0, '0});
    add_row('{0, 0, 0, 0, 0, seg(8388607, -8388608, 8388352, -8388608), 0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    stall_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].new_win) set_window(plan[i].xl, plan[i].xh, plan[i].yl, plan[i].yh);
      if (plan[i].typed && plan[i].want != clip_segment(plan[i].seg))
        report_mismatch($sformatf("typed result of directed row %0d disagrees", i));
      send_word(plan[i].seg);
    end

    // Random part: a new window per phase, stress varying between phases.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      int xl, xh, yl, yh;
      xl = int'($urandom_range(200)) - 100;
      yl = int'($urandom_range(200)) - 100;
      xh = xl + int'($urandom_range(120));
      yh = yl + int'($urandom_range(120));
      if (ph == 3) begin
        xh = xl - 7;
        yh = yl - 3;
      end
      if (ph == 5) begin
        xl = -32768; xh = -32700; yl = 32700; yh = 32767;
      end
      if (ph == 6) begin
        xl = int'($urandom_range(65535)) - 32768;
        xh = int'($urandom_range(65535)) - 32768;
        yl = int'($urandom_range(65535)) - 32768;
        yh = int'($urandom_range(65535)) - 32768;
      end
      set_window(xl, xh, yl, yh);
      gaps_on = (ph != 2);
      stall_pct = (ph == 4) ? 0 : ((ph == 1) ? 60 : 25);
      for (int k = 0; k < WordsPerPhase; k++) begin
        w.start_x = near_coord(win_x_min, win_x_max);
        w.start_y = near_coord(win_y_min, win_y_max);
        w.end_x = near_coord(win_x_min, win_x_max);
        w.end_y = near_coord(win_y_min, win_y_max);
        send_word(w);
      end
    end

    drain();
    $display("Sent %0d segments over %0d window settings; %0d results checked, %0d rejected.",
             words_sent, RandomPhases + 5, words_checked, rejected_seen);
    $display("Mismatches: %0d", error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
